>>> rtl/core/cossim_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cossim_pkg
// Shared types and constants for the streaming cosine similarity block.
// ----------------------------------------------------------------------------
package cossim_pkg;

  localparam int unsigned ElemW = 24;
  localparam int unsigned DotW  = 54;
  localparam int unsigned NormW = 53;
  localparam int unsigned CosW  = 16;

  // Finished accumulator set handed from front to back.
  typedef struct packed {
    logic [DotW-1:0]  dot;
    logic [NormW-1:0] norm_a;
    logic [NormW-1:0] norm_b;
  } acc_set_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } back_state_e;

  localparam logic [16:0] QOne    = 17'd32768;
  localparam logic [15:0] CosMaxP = 16'h7fff;

endpackage
`default_nettype wire

>>> rtl/core/cossim_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cossim_front
// Accepts element pairs, accumulates dot and norm sums, pushes a set on last.
// ----------------------------------------------------------------------------
module cossim_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  [cossim_pkg::ElemW-1:0]    a_value_i,
  input  wire  [cossim_pkg::ElemW-1:0]    b_value_i,
  input  wire                             last_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  output logic                            push_o,
  output cossim_pkg::acc_set_t            push_data_o,
  input  wire                             push_ready_i
);
  import cossim_pkg::*;

  logic                    s_valid_q;
  logic signed [ElemW-1:0] a_q, b_q;
  logic                    last_q;
  logic [DotW-1:0]         dot_q, dot_d;
  logic [NormW-1:0]        na_q, na_d, nb_q, nb_d;
  logic signed [47:0]      ab, aa, bb;
  logic                    advance;

  always_comb begin
    ab    = a_q * b_q;
    aa    = a_q * a_q;
    bb    = b_q * b_q;
    dot_d = dot_q + {{(DotW-48){ab[47]}}, ab};
    na_d  = na_q + {{(NormW-48){1'b0}}, aa};
    nb_d  = nb_q + {{(NormW-48){1'b0}}, bb};
  end

  // A last pair waits here until the queue has room.
  assign advance     = s_valid_q && (!last_q || push_ready_i);
  assign in_ready_o  = !s_valid_q || advance;
  assign push_o      = s_valid_q && last_q && push_ready_i;
  assign push_data_o = '{dot: dot_d, norm_a: na_d, norm_b: nb_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      dot_q     <= '0;
      na_q      <= '0;
      nb_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s_valid_q <= in_valid_i;
      end
      if (advance) begin
        if (last_q) begin
          dot_q <= '0;
          na_q  <= '0;
          nb_q  <= '0;
        end else begin
          dot_q <= dot_d;
          na_q  <= na_d;
          nb_q  <= nb_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q    <= a_value_i;
      b_q    <= b_value_i;
      last_q <= last_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cossim_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cossim_fifo
// Short queue of finished accumulator sets between front and back.
// ----------------------------------------------------------------------------
module cossim_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  cossim_pkg::acc_set_t  push_data_i,
  output logic                  push_ready_o,
  input  wire                   pop_i,
  output cossim_pkg::acc_set_t  pop_data_o,
  output logic                  pop_valid_o
);
  import cossim_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  acc_set_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cossim_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cossim_back
// Sequential unit: norm product, square, long division, square root, result.
// ----------------------------------------------------------------------------
module cossim_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cossim_pkg::acc_set_t         pop_data_i,
  input  wire                          pop_valid_i,
  output logic                         pop_o,
  output logic [cossim_pkg::CosW-1:0]  cosine_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i
);
  import cossim_pkg::*;

  back_state_e      state_q, state_d;
  logic [4:0]       cnt_q;
  logic [NormW-1:0] na_q, nb_q;
  logic [DotW-1:0]  mag_q, mag_in;
  logic             neg_q;
  logic [107:0]     acc_q, acc_d, p_q, m2_q, rem_q, rem2, pp_sh;
  logic [31:0]      f_q;
  logic [19:0]      rs_q, rs, trial;
  logic [15:0]      root_q;
  logic [16:0]      q_q;
  logic [53:0]      opx, opy, pp;
  logic [26:0]      px, py;
  logic             div_ge, sq_ge, out_load;
  logic             out_valid_q;
  logic [CosW-1:0]  cos_q, res;

  assign mag_in = pop_data_i.dot[DotW-1] ? (~pop_data_i.dot + 1'b1) : pop_data_i.dot;

  // Shared 27x27 multiplier, four partial products per multiplication.
  always_comb begin
    opx = cnt_q[2] ? mag_q : {1'b0, na_q};
    opy = cnt_q[2] ? mag_q : {1'b0, nb_q};
    px  = cnt_q[0] ? opx[53:27] : opx[26:0];
    py  = cnt_q[1] ? opy[53:27] : opy[26:0];
    pp  = px * py;
    case (cnt_q[1:0])
      2'd0:    pp_sh = {54'b0, pp};
      2'd3:    pp_sh = {pp, 54'b0};
      default: pp_sh = {27'b0, pp, 27'b0};
    endcase
    acc_d  = acc_q + pp_sh;
    rem2   = {rem_q[106:0], 1'b0};
    div_ge = (rem2 >= p_q);
    rs     = {rs_q[17:0], f_q[31:30]};
    trial  = {2'b0, root_q, 2'b01};
    sq_ge  = (rs >= trial);
    if (neg_q) begin
      res = CosW'(~q_q + 1'b1);
    end else begin
      res = (q_q > {1'b0, CosMaxP}) ? CosMaxP : q_q[CosW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pop_valid_i) state_d = ST_MUL;
      ST_MUL:   if (cnt_q == 5'd7) state_d = ST_CHECK;
      ST_CHECK: begin
        if (p_q == '0 || m2_q >= p_q) state_d = ST_FIN;
        else state_d = ST_DIV;
      end
      ST_DIV:   if (cnt_q == '0) state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == '0) state_d = ST_FIN;
      ST_FIN:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == ST_IDLE) && pop_valid_i;
    out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cnt_q <= '0;
        acc_q <= '0;
        na_q  <= pop_data_i.norm_a;
        nb_q  <= pop_data_i.norm_b;
        mag_q <= mag_in;
        neg_q <= pop_data_i.dot[DotW-1];
      end
      ST_MUL: begin
        acc_q <= (cnt_q[1:0] == 2'd3) ? '0 : acc_d;
        if (cnt_q == 5'd3) p_q <= acc_d;
        if (cnt_q == 5'd7) m2_q <= acc_d;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_CHECK: begin
        rem_q  <= m2_q;
        cnt_q  <= 5'd31;
        rs_q   <= '0;
        root_q <= '0;
        if (p_q == '0) q_q <= '0;
        else q_q <= QOne;
      end
      ST_DIV: begin
        rem_q <= div_ge ? (rem2 - p_q) : rem2;
        f_q   <= {f_q[30:0], div_ge};
        cnt_q <= (cnt_q == '0) ? 5'd15 : cnt_q - 1'b1;
      end
      ST_SQRT: begin
        rs_q   <= sq_ge ? (rs - trial) : rs;
        root_q <= {root_q[14:0], sq_ge};
        f_q    <= {f_q[29:0], 2'b00};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == '0) q_q <= ({1'b0, root_q[14:0], sq_ge} + 17'd1) >> 1;
      end
      ST_FIN: begin
        if (out_load) cos_q <= res;
      end
      default: cnt_q <= '0;
    endcase
  end

  assign cosine_o    = cos_q;
  assign out_valid_o = out_valid_q;

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < p_q))
    else $error("division remainder not below divisor");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_MUL))
    else $error("pop without starting a job");
  a_q_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (q_q <= QOne))
    else $error("magnitude out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(cos_q)))
    else $error("result word dropped while stalled");

endmodule
`default_nettype wire

>>> rtl/core/cosine_similarity_stream_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_stream_top
// Streaming cosine similarity of two vectors, result in signed Q1.15.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o | a_value_i, b_value_i, last_i
// out     | output    | out_valid_o/out_ready_i | cosine_o
//
// While the front is not stalled, pairs enter at one word per cycle and the
// front accumulates one pair per cycle. A last pair pushes its sums into a
// FIFO_DEPTH queue; the back runs 8 multiply, 32 divide, 16 square root steps.
// Reset clears the accumulators, queue and sequencer; no clearing pass.
// The front stalls only when a last pair finds the queue full; the back holds
// its result in the output register until it is taken.
// ----------------------------------------------------------------------------
module cosine_similarity_stream_top #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [cossim_pkg::ElemW-1:0] a_value_i,
  input  wire  [cossim_pkg::ElemW-1:0] b_value_i,
  input  wire                          last_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  output logic [cossim_pkg::CosW-1:0]  cosine_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i
);
  import cossim_pkg::*;

  acc_set_t push_data, pop_data;
  logic     push, push_ready, pop, pop_valid;

  // Accumulate pairs; hand off one set per vector.
  cossim_front u_front (
    .clk_i, .rst_ni, .a_value_i, .b_value_i, .last_i, .in_valid_i, .in_ready_o,
    .push_o(push), .push_data_o(push_data), .push_ready_i(push_ready)
  );

  // Decouple accumulation from the long arithmetic.
  cossim_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .push_ready_o(push_ready), .pop_i(pop), .pop_data_o(pop_data),
    .pop_valid_o(pop_valid)
  );

  // Compute the cosine one set at a time.
  cossim_back u_back (
    .clk_i, .rst_ni, .pop_data_i(pop_data), .pop_valid_i(pop_valid), .pop_o(pop),
    .cosine_o, .out_valid_o, .out_ready_i
  );

endmodule
`default_nettype wire
